### design/assert_macros.svh
// assertion macros shared by the motor feedback decoder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define MFD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// condition in one cycle implies a result in the next
`define MFD_ASSERT_STEP(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);

`endif

### design/mfd_pkg.sv
// shared types and constants of the motor feedback frame decoder
package mfd_pkg;

  // fixed field widths
  typedef logic [1:0]         slot_t;
  typedef logic [15:0]        raw_t;
  typedef logic signed [31:0] q16_t;

  // accepted extended identifier window, both ends included
  localparam logic [28:0] ID_LOW  = 29'h200_0000;
  localparam logic [28:0] ID_HIGH = 29'h300_0000;

  // full scale of each quantity in Q15.16
  localparam int ANGLE_MAX_Q16  = 823550;
  localparam int SPEED_MAX_Q16  = 1966080;
  localparam int TORQUE_MAX_Q16 = 786432;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // register map, one 64-bit word per register
  typedef enum logic [1:0] {
    REG_SLOT_IDS        = 2'd0,
    REG_SLOT_BUSES      = 2'd1,
    REG_DIRECTION_MASK  = 2'd2,
    REG_INITIAL_OFFSETS = 2'd3
  } reg_idx_e;

  // classified frame on its way to the back end
  typedef struct packed {
    slot_t slot;
    logic  rev;
    raw_t  angle_raw;
    raw_t  speed_raw;
    raw_t  torque_raw;
  } mfd_item_t;

endpackage

### design/mfd_front.sv
// front end: takes frames, filters identifiers and matches motor slots
module mfd_front #(
  parameter int SLOTS = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               is_extended_i,
  input  logic [28:0]        frame_id_i,
  input  logic [1:0]         bus_index_i,
  input  mfd_pkg::raw_t      angle_raw_i,
  input  mfd_pkg::raw_t      speed_raw_i,
  input  mfd_pkg::raw_t      torque_raw_i,
  input  logic [31:0]        slot_ids_i,
  input  logic [7:0]         slot_buses_i,
  input  logic [3:0]         direction_mask_i,
  input  logic               full_i,
  output logic               push_o,
  output mfd_pkg::mfd_item_t item_o
);
  import mfd_pkg::*;

  logic      fe_valid_q, fe_valid_d;
  mfd_item_t fe_item_q;
  logic      id_ok;
  logic      hit;
  slot_t     hit_slot;
  logic      accept;
  logic [3:0] motor;

  // identifier window and motor number
  assign motor = frame_id_i[11:8];
  assign id_ok = is_extended_i && (frame_id_i >= ID_LOW) && (frame_id_i <= ID_HIGH);

  // slot match, lowest slot wins
  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if ((slot_ids_i[8*s +: 8] == {4'b0000, motor}) &&
          (slot_buses_i[2*s +: 2] == bus_index_i)) begin
        hit      = 1'b1;
        hit_slot = 2'(s);
      end
    end
  end

  // handshake with the queue
  assign in_stall_o = fe_valid_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = fe_valid_q && !full_i;
  assign item_o     = fe_item_q;

  always_comb begin
    fe_valid_d = fe_valid_q;
    if (accept) begin
      fe_valid_d = id_ok && hit;
    end else if (push_o) begin
      fe_valid_d = 1'b0;
    end
  end

  // classified word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fe_valid_q <= 1'b0;
    end else begin
      fe_valid_q <= fe_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fe_item_q.slot       <= hit_slot;
      fe_item_q.rev        <= direction_mask_i[hit_slot];
      fe_item_q.angle_raw  <= angle_raw_i;
      fe_item_q.speed_raw  <= speed_raw_i;
      fe_item_q.torque_raw <= torque_raw_i;
    end
  end

endmodule

### design/mfd_queue.sv
// short queue that decouples the front end from the back end
`include "assert_macros.svh"

module mfd_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  mfd_pkg::mfd_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output mfd_pkg::mfd_item_t item_o
);
  import mfd_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  mfd_item_t        slots_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = slots_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= item_i;
    end
  end

  `MFD_ASSERT(a_q_no_overflow, clk_i, rst_ni, !(push_i && full_o), "queue written while full")
  `MFD_ASSERT(a_q_no_underflow, clk_i, rst_ni, !(pop_i && !valid_o), "queue read while empty")
  `MFD_ASSERT_STEP(a_q_count_up, clk_i, rst_ni, push_i && !pop_i, count_q == $past(count_q) + 1'b1, "queue count missed a write")

endmodule

### design/mfd_scale.sv
// three-stage linear scaling of one raw code into signed Q15.16
module mfd_scale #(
  parameter int RAW_BITS = 16,
  parameter int MAX_Q    = 823550
) (
  input  logic          clk_i,
  input  logic          load1_i,
  input  logic          load2_i,
  input  logic          load3_i,
  input  mfd_pkg::raw_t raw_i,
  input  logic          rev_i,
  output mfd_pkg::q16_t value_o
);
  // value = round(2*M*r / D) - M with D = 2^RAW_BITS - 1, D odd so no ties
  // 2*M = C*D + E splits the quotient into C*r plus a narrow remainder part
  localparam int D     = (1 << RAW_BITS) - 1;
  localparam int TWO_M = 2 * MAX_Q;
  localparam int C     = TWO_M / D;
  localparam int E     = TWO_M % D;
  localparam int H     = (D - 1) / 2;
  localparam int PW    = $clog2(TWO_M + 1);
  localparam int XW    = 2 * RAW_BITS;
  localparam int QW    = RAW_BITS + 1;

  logic [RAW_BITS-1:0] r;
  logic [PW-1:0]       cr_d, cr1_q, cr2_q;
  logic [XW-1:0]       x_d, x_q;
  logic [RAW_BITS-1:0] a1, b1;
  logic [QW-1:0]       s1, s2, qlo_d, qlo_q;
  logic                a2, ge;
  logic [PW-1:0]       sum;
  logic signed [PW:0]  v;
  logic signed [31:0]  ext, value_d;
  logic signed [31:0]  value_q;

  // stage 1: constant products
  assign r    = raw_i[RAW_BITS-1:0];
  assign cr_d = PW'(C) * PW'(r);
  assign x_d  = XW'(E) * XW'(r) + XW'(H);

  // stage 2: x / D by folding twice on 2^RAW_BITS = D + 1
  assign a1    = x_q[XW-1:RAW_BITS];
  assign b1    = x_q[RAW_BITS-1:0];
  assign s1    = {1'b0, a1} + {1'b0, b1};
  assign a2    = s1[RAW_BITS];
  assign s2    = {1'b0, s1[RAW_BITS-1:0]} + QW'(a2);
  assign ge    = (s2 >= QW'(D));
  assign qlo_d = {1'b0, a1} + QW'(a2) + QW'(ge);

  // stage 3: remove the offset, sign extend and apply direction
  assign sum     = cr2_q + PW'(qlo_q);
  assign v       = $signed({1'b0, sum}) - $signed((PW + 1)'(MAX_Q));
  assign ext     = {{(31 - PW){v[PW]}}, v};
  assign value_d = rev_i ? -ext : ext;
  assign value_o = value_q;

  always_ff @(posedge clk_i) begin
    if (load1_i) begin
      cr1_q <= cr_d;
      x_q   <= x_d;
    end
    if (load2_i) begin
      cr2_q <= cr1_q;
      qlo_q <= qlo_d;
    end
    if (load3_i) begin
      value_q <= value_d;
    end
  end

endmodule

### design/mfd_back.sv
// back end: scaling pipeline, offset capture and output register
`include "assert_macros.svh"

module mfd_back #(
  parameter int SLOTS    = 4,
  parameter int RAW_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  mfd_pkg::mfd_item_t q_item_i,
  output logic               q_pop_o,
  input  logic [63:0]        initial_offsets_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mfd_pkg::slot_t     motor_slot_o,
  output logic               first_frame_o,
  output mfd_pkg::q16_t      angle_out_o,
  output mfd_pkg::q16_t      speed_out_o,
  output mfd_pkg::q16_t      torque_out_o
);
  import mfd_pkg::*;

  logic        v1_q, v2_q, v3_q, v4_q;
  logic        rdy1, rdy2, rdy3, rdy4;
  logic        load2, load3, load4;
  slot_t       slot1_q, slot2_q, slot3_q, slot4_q;
  logic        rev1_q, rev2_q;
  q16_t        angle3, speed3, torque3;
  q16_t        angle_q, speed_q, torque_q, angle_d;
  logic        first_q;
  logic [SLOTS-1:0] running_q;
  logic [31:0] corr_q [SLOTS];
  logic        run_sel;
  logic [31:0] corr_sel, corr_new, init32;
  logic [15:0] offs;

  // ready chain back from the output register
  assign rdy4    = !v4_q || !out_stall_i;
  assign rdy3    = !v3_q || rdy4;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign q_pop_o = q_valid_i && rdy1;
  assign load2   = v1_q && rdy2;
  assign load3   = v2_q && rdy3;
  assign load4   = v3_q && rdy4;

  // scaling units, one per quantity
  mfd_scale #(.RAW_BITS(RAW_BITS), .MAX_Q(ANGLE_MAX_Q16)) u_angle (
    .clk_i(clk_i), .load1_i(q_pop_o), .load2_i(load2), .load3_i(load3),
    .raw_i(q_item_i.angle_raw), .rev_i(rev2_q), .value_o(angle3)
  );
  mfd_scale #(.RAW_BITS(RAW_BITS), .MAX_Q(SPEED_MAX_Q16)) u_speed (
    .clk_i(clk_i), .load1_i(q_pop_o), .load2_i(load2), .load3_i(load3),
    .raw_i(q_item_i.speed_raw), .rev_i(rev2_q), .value_o(speed3)
  );
  mfd_scale #(.RAW_BITS(RAW_BITS), .MAX_Q(TORQUE_MAX_Q16)) u_torque (
    .clk_i(clk_i), .load1_i(q_pop_o), .load2_i(load2), .load3_i(load3),
    .raw_i(q_item_i.torque_raw), .rev_i(rev2_q), .value_o(torque3)
  );

  // per-slot state of the word leaving stage 3
  always_comb begin
    run_sel  = 1'b0;
    corr_sel = '0;
    for (int s = 0; s < SLOTS; s++) begin
      if (slot3_q == 2'(s)) begin
        run_sel  = running_q[s];
        corr_sel = corr_q[s];
      end
    end
  end

  // offset: Q3.12 sign extended to Q15.16, plus correction
  assign offs     = initial_offsets_i[{slot3_q, 4'b0000} +: 16];
  assign init32   = {{12{offs[15]}}, offs, 4'b0000};
  assign corr_new = run_sel ? corr_sel : corr_sel - angle3;
  assign angle_d  = angle3 + init32 + corr_new;

  // pipeline valid bits and slot state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      running_q <= '0;
      for (int s = 0; s < SLOTS; s++) begin
        corr_q[s] <= '0;
      end
    end else begin
      if (rdy1) v1_q <= q_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (load4 && !run_sel) begin
        for (int s = 0; s < SLOTS; s++) begin
          if (slot3_q == 2'(s)) begin
            running_q[s] <= 1'b1;
            corr_q[s]    <= corr_new;
          end
        end
      end
    end
  end

  // side data travelling with each stage, output register
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      slot1_q <= q_item_i.slot;
      rev1_q  <= q_item_i.rev;
    end
    if (load2) begin
      slot2_q <= slot1_q;
      rev2_q  <= rev1_q;
    end
    if (load3) begin
      slot3_q <= slot2_q;
    end
    if (load4) begin
      slot4_q  <= slot3_q;
      first_q  <= !run_sel;
      angle_q  <= angle_d;
      speed_q  <= speed3;
      torque_q <= torque3;
    end
  end

  assign out_valid_o   = v4_q;
  assign motor_slot_o  = slot4_q;
  assign first_frame_o = first_q;
  assign angle_out_o   = angle_q;
  assign speed_out_o   = speed_q;
  assign torque_out_o  = torque_q;

  `MFD_ASSERT_STEP(a_run_sticky, clk_i, rst_ni, 1'b1, (running_q & $past(running_q)) == $past(running_q), "running flag cleared outside reset")
  `MFD_ASSERT_STEP(a_first_marked, clk_i, rst_ni, load4 && !run_sel, out_valid_o && first_frame_o, "first frame of a slot not flagged")

endmodule

### design/motor_feedback_frame_decoder_top.sv
// Motor feedback frame decoder: one received CAN frame in, zero or one
// decoded feedback word out.
// Input channel: in_valid_i/in_stall_o with the frame fields. Extended
// frames with identifier 0x2000000..0x3000000 whose motor number (id bits
// 11..8) and bus match a configured slot give one output word; all other
// frames are taken and dropped without a result.
// Output channel: out_valid_o/out_stall_i with slot, first-frame flag and
// angle, speed, torque in signed Q15.16.
// Path from acceptance to out_valid_o: the front register, the two-entry
// queue, three scaling stages and the output register. Throughput is one
// word per cycle while out_stall_i is low, set by the scaling pipeline
// whose constant multipliers are all registered.
// While the receiver stalls, the output register holds its word, the
// pipeline fills and then the queue; in_stall_o rises only once the front
// register and the queue are both full.
// Reset clears the configuration registers, the running flags and the
// offset corrections; no clearing pass is needed afterwards.
// Configuration: APB port, 64-bit registers at byte addresses 0, 8, 16,
// 24, written by the user only while no frame is in flight (unchecked).
module motor_feedback_frame_decoder_top #(
  parameter int SLOTS    = 4,
  parameter int RAW_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic          is_extended_i,
  input  logic [28:0]   frame_id_i,
  input  logic [1:0]    bus_index_i,
  input  mfd_pkg::raw_t angle_raw_i,
  input  mfd_pkg::raw_t speed_raw_i,
  input  mfd_pkg::raw_t torque_raw_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output mfd_pkg::slot_t motor_slot_o,
  output logic          first_frame_o,
  output mfd_pkg::q16_t angle_out_o,
  output mfd_pkg::q16_t speed_out_o,
  output mfd_pkg::q16_t torque_out_o
);
  import mfd_pkg::*;

  logic [31:0] slot_ids_q;
  logic [7:0]  slot_buses_q;
  logic [3:0]  direction_mask_q;
  logic [63:0] initial_offsets_q;
  reg_idx_e    reg_idx;
  logic        wr_en;
  logic        q_full, q_push, q_valid, q_pop;
  mfd_item_t   fe_item, q_item;

  // register access
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[4:3]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_ids_q        <= '0;
      slot_buses_q      <= '0;
      direction_mask_q  <= '0;
      initial_offsets_q <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SLOT_IDS:        slot_ids_q        <= pwdata[31:0];
        REG_SLOT_BUSES:      slot_buses_q      <= pwdata[7:0];
        REG_DIRECTION_MASK:  direction_mask_q  <= pwdata[3:0];
        REG_INITIAL_OFFSETS: initial_offsets_q <= pwdata;
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      REG_SLOT_IDS:        prdata = {32'd0, slot_ids_q};
      REG_SLOT_BUSES:      prdata = {56'd0, slot_buses_q};
      REG_DIRECTION_MASK:  prdata = {60'd0, direction_mask_q};
      REG_INITIAL_OFFSETS: prdata = initial_offsets_q;
      default:             prdata = '0;
    endcase
  end

  // frame filter and slot match
  mfd_front #(.SLOTS(SLOTS)) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .is_extended_i   (is_extended_i),
    .frame_id_i      (frame_id_i),
    .bus_index_i     (bus_index_i),
    .angle_raw_i     (angle_raw_i),
    .speed_raw_i     (speed_raw_i),
    .torque_raw_i    (torque_raw_i),
    .slot_ids_i      (slot_ids_q),
    .slot_buses_i    (slot_buses_q),
    .direction_mask_i(direction_mask_q),
    .full_i          (q_full),
    .push_o          (q_push),
    .item_o          (fe_item)
  );

  // decoupling queue
  mfd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (fe_item),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .item_o (q_item)
  );

  // scaling, offsets and output register
  mfd_back #(.SLOTS(SLOTS), .RAW_BITS(RAW_BITS)) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_item_i         (q_item),
    .q_pop_o          (q_pop),
    .initial_offsets_i(initial_offsets_q),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .motor_slot_o     (motor_slot_o),
    .first_frame_o    (first_frame_o),
    .angle_out_o      (angle_out_o),
    .speed_out_o      (speed_out_o),
    .torque_out_o     (torque_out_o)
  );

endmodule
